### rtl/max_segment_cut_count_macros.svh
// Assertion macros for the segment cut block.
// Used by files that hold concurrent checks; expects clk_i and rst_ni in scope.
`ifndef MAX_SEGMENT_CUT_COUNT_MACROS_SVH
`define MAX_SEGMENT_CUT_COUNT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define MSCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define MSCC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/mscc_pkg.sv
// Shared constants and types for the segment cut block.
// No dependencies.
package mscc_pkg;

  localparam int unsigned MaxLen     = 1024;
  localparam int unsigned LenW       = 11;
  localparam int unsigned EntW       = 12;
  localparam int unsigned TableDepth = MaxLen + 1;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned InDataW    = 48;
  localparam int unsigned OutDataW   = 16;

  typedef logic [LenW-1:0]  len_t;
  typedef logic [EntW-1:0]  entry_t;
  typedef logic [AddrW-1:0] addr_t;

  localparam entry_t Unreach = {EntW{1'b1}};

  typedef struct packed {
    logic   use_prev;
    entry_t prev;
    entry_t best;
  } step_in_t;

endpackage

### rtl/mscc_ram.sv
// Simple dual-port table memory: one write port, one registered read port.
// Generic; no package dependency.
module mscc_ram #(
  parameter int unsigned Depth = 1025,
  parameter int unsigned AddrW = 11,
  parameter int unsigned DataW = 12
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/mscc_best_unit.sv
// Shared add-and-compare unit: folds one table entry plus one piece into the best count.
// Depends on mscc_pkg.
module mscc_best_unit (
  input  mscc_pkg::step_in_t step_i,
  output mscc_pkg::entry_t   best_o
);

  mscc_pkg::entry_t cand;

  always_comb begin
    cand   = step_i.prev + mscc_pkg::entry_t'(1);
    best_o = step_i.best;
    if (step_i.use_prev && (step_i.prev != mscc_pkg::Unreach)) begin
      if ((step_i.best == mscc_pkg::Unreach) || (cand > step_i.best)) begin
        best_o = cand;
      end
    end
  end

endmodule

### rtl/max_segment_cut_count.sv
// Top level of the segment cut block: sequencer, table memory and best-count unit.
// Depends on mscc_pkg, mscc_ram, mscc_best_unit and the macros header.
//
//   channel | dir | tdata bits (low to high)
//   s_      | in  | total_length[10:0] first_length[21:11] second_length[32:22]
//           |     | third_length[43:33], zero fill to 48
//   m_      | out | piece_count[10:0], zero fill to 16
//
// A query with total T in 1..1024 steps through every length from 1 to T in turn:
// three table reads per length through the single memory read port.
// A zero total or one above 1024 gives 0 without a run, table untouched.
// s_tready_o is high only between queries; a result waiting on m_tready_i
// does not block the next accept, but the next result holds until it drains.
// Reset is asynchronous active low; the table needs no clearing.
`include "max_segment_cut_count_macros.svh"

module max_segment_cut_count (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [47:0] s_tdata_i,   // total_length, first_length, second_length, third_length
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [15:0] m_tdata_o    // piece_count
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StRun   = 2'd1;
  localparam logic [1:0] StFlush = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  localparam logic [1:0] PhA = 2'd0;
  localparam logic [1:0] PhB = 2'd1;
  localparam logic [1:0] PhC = 2'd2;

  logic [1:0] state_q, state_d;
  logic [1:0] phase_q, phase_d;
  mscc_pkg::len_t len_q, len_d;
  logic use_q, use_d;
  logic fwd_q, fwd_d;
  logic m_valid_q, m_valid_d;

  mscc_pkg::len_t tot_q, tot_d;
  mscc_pkg::len_t a_q, a_d;
  mscc_pkg::len_t b_q, b_d;
  mscc_pkg::len_t c_q, c_d;
  mscc_pkg::entry_t best_q, best_d;
  mscc_pkg::entry_t wdata_q, wdata_d;
  mscc_pkg::len_t res_q, res_d;
  mscc_pkg::len_t m_data_q, m_data_d;

  logic ram_we;
  mscc_pkg::addr_t ram_waddr, ram_raddr;
  mscc_pkg::entry_t ram_wdata, ram_rdata;

  mscc_pkg::len_t piece;
  logic fits;
  mscc_pkg::step_in_t step;
  mscc_pkg::entry_t new_best;

  mscc_pkg::len_t in_tot, in_a, in_b, in_c;

  assign in_tot = s_tdata_i[10:0];
  assign in_a   = s_tdata_i[21:11];
  assign in_b   = s_tdata_i[32:22];
  assign in_c   = s_tdata_i[43:33];

  mscc_ram #(
    .Depth(mscc_pkg::TableDepth),
    .AddrW(mscc_pkg::AddrW),
    .DataW(mscc_pkg::EntW)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign step.use_prev = use_q;
  assign step.prev     = fwd_q ? wdata_q : ram_rdata;
  assign step.best     = best_q;

  mscc_best_unit u_best (
    .step_i(step),
    .best_o(new_best)
  );

  always_comb begin
    case (phase_q)
      PhA:     piece = a_q;
      PhB:     piece = b_q;
      default: piece = c_q;
    endcase
  end

  assign fits      = (piece != '0) && (piece <= len_q);
  assign ram_raddr = mscc_pkg::addr_t'(len_q - piece);

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    len_d     = len_q;
    use_d     = 1'b0;
    fwd_d     = 1'b0;
    m_valid_d = m_valid_q;
    tot_d     = tot_q;
    a_d       = a_q;
    b_d       = b_q;
    c_d       = c_q;
    best_d    = best_q;
    wdata_d   = wdata_q;
    res_d     = res_q;
    m_data_d  = m_data_q;
    ram_we    = 1'b0;
    ram_waddr = mscc_pkg::addr_t'(len_q);
    ram_wdata = new_best;

    if (m_valid_q && m_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (s_tvalid_i) begin
          tot_d = in_tot;
          a_d   = in_a;
          b_d   = in_b;
          c_d   = in_c;
          if ((in_tot == '0) || (in_tot > mscc_pkg::len_t'(mscc_pkg::MaxLen))) begin
            res_d   = '0;
            state_d = StDone;
          end else begin
            len_d   = mscc_pkg::len_t'(1);
            phase_d = PhA;
            state_d = StRun;
          end
        end
      end
      StRun: begin
        use_d = fits;
        case (phase_q)
          PhA: begin
            ram_we    = 1'b1;
            ram_waddr = mscc_pkg::addr_t'(len_q - mscc_pkg::len_t'(1));
            ram_wdata = (len_q == mscc_pkg::len_t'(1)) ? '0 : new_best;
            wdata_d   = ram_wdata;
            fwd_d     = (ram_waddr == ram_raddr);
            best_d    = mscc_pkg::Unreach;
            phase_d   = PhB;
          end
          PhB: begin
            best_d  = new_best;
            phase_d = PhC;
          end
          default: begin
            best_d  = new_best;
            phase_d = PhA;
            if (len_q == tot_q) begin
              state_d = StFlush;
            end else begin
              len_d = len_q + mscc_pkg::len_t'(1);
            end
          end
        endcase
      end
      StFlush: begin
        ram_we    = 1'b1;
        ram_waddr = mscc_pkg::addr_t'(len_q);
        ram_wdata = new_best;
        wdata_d   = new_best;
        res_d     = (new_best == mscc_pkg::Unreach) ? '0 : new_best[mscc_pkg::LenW-1:0];
        state_d   = StDone;
      end
      default: begin
        if (!m_valid_q || m_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = res_q;
          state_d   = StIdle;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      phase_q   <= PhA;
      len_q     <= '0;
      use_q     <= 1'b0;
      fwd_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      len_q     <= len_d;
      use_q     <= use_d;
      fwd_q     <= fwd_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tot_q    <= tot_d;
    a_q      <= a_d;
    b_q      <= b_d;
    c_q      <= c_d;
    best_q   <= best_d;
    wdata_q  <= wdata_d;
    res_q    <= res_d;
    m_data_q <= m_data_d;
  end

  assign s_tready_o = (state_q == StIdle);
  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {{(16 - mscc_pkg::LenW){1'b0}}, m_data_q};

  `MSCC_ASSERT(a_start_run, (s_tvalid_i && s_tready_o && (in_tot != '0) && (in_tot <= mscc_pkg::len_t'(mscc_pkg::MaxLen))) |=> ((state_q == StRun) && (len_q == mscc_pkg::len_t'(1))), "accepted query did not start at length one")
  `MSCC_ASSERT(a_len_range, (state_q == StRun) |-> ((len_q != '0) && (len_q <= tot_q)), "length counter out of range")
  `MSCC_ASSERT(a_wr_range, ram_we |-> (ram_waddr <= mscc_pkg::addr_t'(tot_q)), "table write beyond total")
  `MSCC_ASSERT(a_fwd_src, fwd_q |-> $past(ram_we), "forward without preceding write")
  `MSCC_ASSERT_ALWAYS(a_phase_code, !rst_ni || (phase_q != 2'd3), "phase counter out of range")

endmodule

### test/tb_max_segment_cut_count.sv
// Self-checking testbench for max_segment_cut_count: directed and random cut queries.
// Depends on mscc_pkg and the max_segment_cut_count RTL; the cut table is predicted
// in a small scoreboard class.
module tb_max_segment_cut_count
  import mscc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit   = 40000;
  localparam int unsigned HoldCycles  = 7 * MaxLen;
  localparam int unsigned HoldAfter   = 40;
  localparam int unsigned DrainCycles = 3 * MaxLen + 30;
  localparam int unsigned RandomItems = 175;

  typedef enum logic [1:0] {
    RxOpen,
    RxCoin,
    RxSparse,
    RxDense
  } rx_mode_e;

  class cut_count_board;
    entry_t      seg_table [0:MaxLen];
    len_t        last_filled;
    len_t        counts_due [$];
    int unsigned errors;
    int unsigned checked;

    function void note_query(len_t total, len_t first, len_t second, len_t third);
      len_t        pieces [3];
      entry_t      best;
      entry_t      prev;
      entry_t      cand;
      int unsigned l;
      pieces[0] = first;
      pieces[1] = second;
      pieces[2] = third;
      if (total > MaxLen) begin
        counts_due.push_back('0);
        return;
      end
      seg_table[0] = '0;
      for (l = 1; l <= total; l++) begin
        best = Unreach;
        foreach (pieces[k]) begin
          if (pieces[k] != 0 && pieces[k] <= l) begin
            prev = seg_table[l - pieces[k]];
            if (prev != Unreach) begin
              cand = prev + 1'b1;
              if (best == Unreach || cand > best) best = cand;
            end
          end
        end
        seg_table[l] = best;
      end
      last_filled = total;
      if (seg_table[total] == Unreach) counts_due.push_back('0);
      else counts_due.push_back(seg_table[total][LenW-1:0]);
    endfunction

    function void check_count(len_t actual);
      len_t want;
      checked++;
      if (counts_due.size() == 0) begin
        if (errors < 10) $display("%t: piece_count %0d with no query pending", $realtime, actual);
        errors++;
        return;
      end
      want = counts_due.pop_front();
      if (actual !== want) begin
        if (errors < 10) begin
          $display("%t: piece_count expected %0d got %0d", $realtime, want, actual);
        end
        errors++;
      end
    endfunction

    function int unsigned pending();
      return counts_due.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni     = 1'b0;
  logic                s_tvalid_i = 1'b0;
  logic                s_tready_o;
  logic [InDataW-1:0]  s_tdata_i  = '0;
  logic                m_tvalid_o;
  logic                m_tready_i = 1'b0;
  logic [OutDataW-1:0] m_tdata_o;

  cut_count_board board = new();
  int unsigned    idle_cycles = 0;
  int unsigned    burst_left  = 0;

  max_segment_cut_count uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (s_tvalid_i && s_tready_o) begin
      board.note_query(s_tdata_i[10:0], s_tdata_i[21:11], s_tdata_i[32:22], s_tdata_i[43:33]);
    end
    if (m_tvalid_o && m_tready_i) board.check_count(m_tdata_o[LenW-1:0]);
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("max_segment_cut_count: mismatch");
      $finish;
    end
  end

  task automatic send_query(input len_t total, input len_t first, input len_t second,
                            input len_t third);
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {4'b0, third, second, first, total};
    do @(posedge clk_i); while (!s_tready_o);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if ($urandom_range(0, 3) != 0) begin
        s_tvalid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // receiver: random stall modes, plus one long hold-off to back up the block
  initial begin : rx_side
    rx_mode_e    mode;
    int unsigned mode_left;
    bit          held;
    mode      = RxOpen;
    mode_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && board.checked >= HoldAfter) begin
        held = 1'b1;
        m_tready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (mode)
        RxOpen:   m_tready_i <= 1'b1;
        RxCoin:   m_tready_i <= 1'($urandom_range(0, 1));
        RxSparse: m_tready_i <= ($urandom_range(0, 3) == 0);
        default:  m_tready_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  initial begin : tx_side
    len_t        total;
    len_t        first;
    len_t        second;
    len_t        third;
    int unsigned kind;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_query(0, 1, 2, 3);
    send_query(1, 1, 1, 1);
    send_query(1024, 1, 1, 1);
    send_query(1024, 2047, 2047, 2047);
    send_query(2047, 1, 2, 3);
    send_query(1025, 1, 1, 1);
    send_query(10, 0, 0, 3);
    send_query(9, 0, 3, 0);
    send_query(7, 5, 3, 2);
    send_query(11, 5, 3, 2);
    send_query(17, 4, 6, 8);
    send_query(23, 11, 12, 13);
    send_query(1024, 1024, 1, 1024);
    send_query(1024, 1024, 1024, 1024);
    send_query(1023, 1024, 7, 512);
    send_query(1000, 3, 7, 1024);
    send_query(5, 0, 0, 0);

    for (int unsigned i = 0; i < RandomItems; i++) begin
      kind   = $urandom_range(0, 99);
      total  = len_t'($urandom_range(1, 80));
      first  = len_t'($urandom_range(1, 20));
      second = len_t'($urandom_range(1, 20));
      third  = len_t'($urandom_range(1, 20));
      if (kind < 5) begin
        total = 0;
      end else if (kind < 10) begin
        total = len_t'($urandom_range(1025, 2047));
      end else if (kind < 15) begin
        total = len_t'($urandom_range(900, 1024));
      end else if (kind < 25) begin
        total  = len_t'($urandom_range(0, 2047));
        first  = len_t'($urandom_range(0, 2047));
        second = len_t'($urandom_range(0, 2047));
        third  = len_t'($urandom_range(0, 2047));
      end else begin
        if ($urandom_range(0, 9) == 0) first = 0;
        if ($urandom_range(0, 9) == 0) second = 0;
        if ($urandom_range(0, 9) == 0) third = 0;
      end
      send_query(total, first, second, third);
    end
    s_tvalid_i <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("max_segment_cut_count: match");
    end else begin
      $display("max_segment_cut_count: mismatch");
    end
    $finish;
  end

endmodule

### max_segment_cut_count.f
+incdir+rtl
rtl/mscc_pkg.sv
rtl/mscc_ram.sv
rtl/mscc_best_unit.sv
rtl/max_segment_cut_count.sv
test/tb_max_segment_cut_count.sv
